FILE: hw/rtl/namespace_hash_derivation_unit_defines.svh
// Assertion macros shared by the namespace hash derivation RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef NAMESPACE_HASH_DERIVATION_UNIT_DEFINES_SVH
`define NAMESPACE_HASH_DERIVATION_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define NHD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define NHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition must never hold.
`define NHD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/nhd_pkg.sv
// Shared types, constants and functions for the namespace hash derivation unit.
// No dependencies; every RTL module imports it.
package nhd_pkg;

   // FNV lane start values and low-lane byte offset
   localparam logic [63:0] LANE_HIGH_INIT  = 64'hCBF29CE484222325;
   localparam logic [63:0] LANE_LOW_INIT   = 64'h84222325CBF29CE4;
   localparam logic [8:0]  LOW_BYTE_OFFSET = 9'h09D;

   // splitmix64 finalizer constants
   localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

   // fallback salts
   localparam logic [63:0] SALT_HIGH = 64'h4F53545444464944;
   localparam logic [63:0] SALT_LOW  = 64'h534156454E414D45;

   // job queue between front and back; depth must be a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_WORLD_SEED = 2'd0,
      CSR_MAP_WIDTH  = 2'd1,
      CSR_MAP_HEIGHT = 2'd2,
      CSR_START_YEAR = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       empty_string;
   } req_type;

   typedef struct packed {
      logic [63:0] space_high;
      logic [63:0] space_low;
      logic        used_fallback;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        world_seed;
      logic [31:0]        map_width;
      logic [31:0]        map_height;
      logic signed [31:0] start_year;
   } cfg_type;

   // one finished string or fallback request travelling front to back
   typedef struct packed {
      logic        use_fallback;
      logic [63:0] lane_high;
      logic [63:0] lane_low;
   } job_type;

   // multiply by the FNV prime 2^40 + 0x1B3, modulo 2^64
   function automatic logic [63:0] fnv_prime_mul(input logic [63:0] x);
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

FILE: hw/rtl/nhd_front.sv
// Front part: absorbs identifier bytes into the two FNV lanes and hands
// finished strings or fallback requests to the job queue. Uses nhd_pkg.
module nhd_front
   import nhd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output logic    push,
   output job_type job
);

   logic [63:0] lane_high_ff, lane_high_in;
   logic [63:0] lane_low_ff, lane_low_in;
   logic [63:0] high_step;
   logic [63:0] low_step;

   // fold one byte into both lanes
   always_comb begin
      high_step = fnv_prime_mul(lane_high_ff ^ {56'd0, req.data_byte});
      low_step  = fnv_prime_mul(lane_low_ff ^
                                {55'd0, {1'b0, req.data_byte} + LOW_BYTE_OFFSET});
   end

   // hand over on the last byte or an empty string, then restart the lanes
   always_comb begin
      push              = accept && (req.empty_string || req.last_byte);
      job.use_fallback  = req.empty_string;
      job.lane_high     = high_step;
      job.lane_low      = low_step;
      lane_high_in      = lane_high_ff;
      lane_low_in       = lane_low_ff;
      if (accept) begin
         if (push) begin
            lane_high_in = LANE_HIGH_INIT;
            lane_low_in  = LANE_LOW_INIT;
         end else begin
            lane_high_in = high_step;
            lane_low_in  = low_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_high_ff <= LANE_HIGH_INIT;
         lane_low_ff  <= LANE_LOW_INIT;
      end else begin
         lane_high_ff <= lane_high_in;
         lane_low_ff  <= lane_low_in;
      end
   end

endmodule

FILE: hw/rtl/nhd_queue.sv
// Short job queue that decouples the byte front from the finalizer back.
// Uses nhd_pkg for the job type and depth.
`include "namespace_hash_derivation_unit_defines.svh"
module nhd_queue
   import nhd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head_job
);

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = entries_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the word at the write slot
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   `NHD_ASSERT_NEVER(a_no_overflow, clock, reset, push && full,
                     "push into a full job queue")
   `NHD_ASSERT_NEVER(a_no_underflow, clock, reset, pop && !not_empty,
                     "pop from an empty job queue")
   `NHD_ASSERT_NEVER(a_count_bound, clock, reset,
                     count_ff > (QUEUE_PTR_W+1)'(QUEUE_DEPTH),
                     "job queue occupancy beyond its depth")

endmodule

FILE: hw/rtl/nhd_mix.sv
// Iterative splitmix64 finalizer: each 64x64 multiply runs as three
// 32x32 partial products on one shared multiplier. Uses nhd_pkg.
module nhd_mix
   import nhd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] operand,
   output logic        done,
   output logic [63:0] result
);

   // partial product order: low*low, high*low, low*high
   localparam logic [1:0] PART_LL = 2'd0;
   localparam logic [1:0] PART_HL = 2'd1;
   localparam logic [1:0] PART_LH = 2'd2;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        round_ff, round_in;
   logic [1:0]  part_ff, part_in;
   logic [63:0] opnd_ff, opnd_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] result_ff, result_in;
   logic [63:0] pre_add;
   logic [63:0] mul_const;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] product;
   logic [63:0] acc_sum;

   assign done   = done_ff;
   assign result = result_ff;

   always_comb begin
      pre_add   = operand + MIX_GOLDEN;
      mul_const = round_ff ? MIX_MUL_B : MIX_MUL_A;
      mul_a     = (part_ff == PART_HL) ? opnd_ff[63:32] : opnd_ff[31:0];
      mul_b     = (part_ff == PART_LH) ? mul_const[63:32] : mul_const[31:0];
      product   = {32'd0, mul_a} * {32'd0, mul_b};
      acc_sum   = acc_ff + {product[31:0], 32'd0};
   end

   // step through the partial products of both rounds
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      round_in  = round_ff;
      part_in   = part_ff;
      opnd_in   = opnd_ff;
      acc_in    = acc_ff;
      result_in = result_ff;
      if (start) begin
         busy_in  = 1'b1;
         round_in = 1'b0;
         part_in  = PART_LL;
         opnd_in  = pre_add ^ (pre_add >> 30);
      end else if (busy_ff) begin
         unique case (part_ff)
            PART_LL: begin
               acc_in  = product;
               part_in = PART_HL;
            end
            PART_HL: begin
               acc_in  = acc_sum;
               part_in = PART_LH;
            end
            PART_LH: begin
               part_in = PART_LL;
               if (!round_ff) begin
                  opnd_in  = acc_sum ^ (acc_sum >> 27);
                  round_in = 1'b1;
               end else begin
                  result_in = acc_sum ^ (acc_sum >> 31);
                  busy_in   = 1'b0;
                  done_in   = 1'b1;
               end
            end
            default: begin
               part_in = PART_LL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= 1'b0;
         part_ff  <= PART_LL;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         round_ff <= round_in;
         part_ff  <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff   <= opnd_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

endmodule

FILE: hw/rtl/nhd_back.sv
// Back part: takes jobs from the queue, finalizes the lanes or the fallback
// words on the shared mixer and holds the result word. Uses nhd_pkg, nhd_mix.
`include "namespace_hash_derivation_unit_defines.svh"
module nhd_back
   import nhd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_valid,
   input  job_type job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_STR_HI = 5'b00010,
      S_STR_LO = 5'b00100,
      S_FB_HI  = 5'b01000,
      S_FB_LO  = 5'b10000
   } back_state_type;

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   logic [63:0]    word_hi_ff, word_hi_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic           mix_start;
   logic [63:0]    mix_operand;
   logic           mix_done;
   logic [63:0]    mix_result;
   logic [63:0]    geometry;
   logic [63:0]    fb_high_seed;
   logic [63:0]    fb_low_seed;

   nhd_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .start   (mix_start),
      .operand (mix_operand),
      .done    (mix_done),
      .result  (mix_result)
   );

   // fallback inputs from seed, map size and year
   always_comb begin
      geometry     = {cfg.map_width, cfg.map_height};
      fb_high_seed = {cfg.world_seed, 32'd0} ^ geometry ^ SALT_HIGH;
      fb_low_seed  = geometry ^ {cfg.start_year, 32'd0} ^ {32'd0, cfg.world_seed}
                     ^ SALT_LOW;
   end

   assign pop       = (state_ff == S_IDLE) && job_valid && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequence the finalizer passes and load the result word
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      word_hi_in   = word_hi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mix_start    = 1'b0;
      mix_operand  = job_ff.lane_low;
      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               job_in    = job;
               mix_start = 1'b1;
               if (job.use_fallback) begin
                  mix_operand = fb_high_seed;
                  state_in    = S_FB_HI;
               end else begin
                  mix_operand = job.lane_high;
                  state_in    = S_STR_HI;
               end
            end
         end
         S_STR_HI: begin
            if (mix_done) begin
               word_hi_in  = mix_result;
               mix_start   = 1'b1;
               mix_operand = job_ff.lane_low;
               state_in    = S_STR_LO;
            end
         end
         S_STR_LO: begin
            if (mix_done) begin
               if (word_hi_ff == '0 && mix_result == '0) begin
                  mix_start   = 1'b1;
                  mix_operand = fb_high_seed;
                  state_in    = S_FB_HI;
               end else begin
                  rsp_in.space_high    = word_hi_ff;
                  rsp_in.space_low     = mix_result;
                  rsp_in.used_fallback = 1'b0;
                  rsp_valid_in         = 1'b1;
                  state_in             = S_IDLE;
               end
            end
         end
         S_FB_HI: begin
            if (mix_done) begin
               word_hi_in  = mix_result;
               mix_start   = 1'b1;
               mix_operand = fb_low_seed;
               state_in    = S_FB_LO;
            end
         end
         S_FB_LO: begin
            if (mix_done) begin
               rsp_in.space_high    = word_hi_ff;
               rsp_in.space_low     = (word_hi_ff == '0 && mix_result == '0) ?
                                      64'd1 : mix_result;
               rsp_in.used_fallback = 1'b1;
               rsp_valid_in         = 1'b1;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      word_hi_ff <= word_hi_in;
      rsp_ff     <= rsp_in;
   end

   `NHD_ASSERT_IMPLY(a_done_when_busy, clock, reset, mix_done, state_ff != S_IDLE,
                     "mixer finished with no job in hand")
   `NHD_ASSERT_IMPLY(a_fallback_nonzero, clock, reset,
                     rsp_valid_ff && rsp_ff.used_fallback,
                     rsp_ff.space_high != '0 || rsp_ff.space_low != '0,
                     "fallback namespace is all zero")
   `NHD_ASSERT_IMPLY(a_string_nonzero, clock, reset,
                     rsp_valid_ff && !rsp_ff.used_fallback,
                     rsp_ff.space_high != '0 || rsp_ff.space_low != '0,
                     "zero string namespace not replaced")
   `NHD_ASSERT_NEXT(a_result_from_last_pass, clock, reset,
                    !rsp_valid_ff && state_ff == S_IDLE, !rsp_valid_ff,
                    "result word raised with no pass finished")

endmodule

FILE: hw/rtl/namespace_hash_derivation_unit.sv
// Top level of the namespace hash derivation unit: configuration registers,
// byte front, job queue and finalizer back. Uses nhd_pkg and the nhd_ modules.
//
//   port group  direction  handshake           word
//   req_        in         req_valid/req_stall  req_type: byte, last, empty
//   rsp_        out        rsp_valid/rsp_stall  rsp_type: 128-bit namespace, fallback
//   csr_        in         csr_write_en         2-bit index, 32-bit data
//
// Bytes are taken one per cycle while the two-entry job queue has room.
// A string namespace is finalized by a high-word pass and then a low-word pass
// on the mixer; a fallback likewise, and a string whose words both finalize
// to zero then runs the fallback passes too. The mixer has one shared 32x32
// multiplier: three partial products per multiply, two multiplies per 64-bit word.
// Reset is synchronous; it restarts the lanes and clears the queue, sequencer and registers.
// req_stall rises while the queue is full; rsp_stall holds the result and
// keeps the next job waiting in the queue.
module namespace_hash_derivation_unit
   import nhd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_write_en,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   logic    req_accept;
   logic    q_push;
   job_type q_push_job;
   logic    q_pop;
   logic    q_full;
   logic    q_not_empty;
   job_type q_head_job;

   // decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_WORLD_SEED: cfg_in.world_seed = csr_write_data;
            CSR_MAP_WIDTH:  cfg_in.map_width  = csr_write_data;
            CSR_MAP_HEIGHT: cfg_in.map_height = csr_write_data;
            CSR_START_YEAR: cfg_in.start_year = csr_write_data;
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // hold input words while the queue is full
   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   nhd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_data),
      .push   (q_push),
      .job    (q_push_job)
   );

   nhd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_job  (q_head_job)
   );

   nhd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (q_not_empty),
      .job       (q_head_job),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
